// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BPNR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BPNR_ASSERT(lbl, prop, msg)
`define BPNR_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/bpnr_pkg.sv =====
`default_nettype none
package bpnr_pkg;

  localparam int RADIUS       = 2;
  localparam int WIN          = 2 * RADIUS + 1;
  localparam int STORED_LINES = WIN - 1;
  localparam int SKIP_LEN     = 2;
  localparam int MAX_WIDTH    = 1024;
  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int CFG_W_BITS   = 11;
  localparam int CFG_H_BITS   = 12;
  localparam int ROW_W        = CFG_H_BITS;
  localparam int MAX_HEIGHT   = (1 << CFG_H_BITS) - 1;
  localparam int EW_W         = $clog2(MAX_WIDTH + 1);
  localparam int TOT_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LAG_W        = $clog2(3 * MAX_WIDTH + 4);
  localparam int LIN_W        = TOT_W + 1;
  localparam int WORD_W       = STORED_LINES * PIX_W;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int RESET_W      = 640;
  localparam int RESET_H      = 480;

  localparam logic [PIX_W-1:0] FILL_VALUE = PIX_W'(255);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // One column of the 5x5 window, element 0 is the oldest row.
  typedef logic [WIN-1:0][PIX_W-1:0] stack_t;
  typedef logic [STORED_LINES-1:0][PIX_W-1:0] word_t;

  typedef enum logic {PH_FILL, PH_DRAIN} phase_t;

  function automatic logic [EW_W-1:0] clamp_width(input logic [CFG_W_BITS-1:0] v);
    logic [EW_W-1:0] r;
    if (v == '0) begin
      r = EW_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = EW_W'(MAX_WIDTH);
    end else begin
      r = EW_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CFG_H_BITS-1:0] clamp_height(input logic [CFG_H_BITS-1:0] v);
    return (v == '0) ? CFG_H_BITS'(1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bpnr_ram.sv =====
`default_nettype none
module bpnr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/binary_pepper_noise_removal.sv =====
// Throughput: one beat per cycle in both phases, pixels and flush ticks alike, while m_tready does not hold the output.
// Order: pixel p leaves through the window stage and the output register, on the beat
// carrying pixel p + 3*W + 3; the last 3*W + 3 pixels leave one per flush tick.
// The column word RAM (one read, one write per cycle) gives the registered fetch stage.
// Reset: synchronous; counters cleared, width 640 and height 480 restored,
// RAM contents left as they are (no clearing pass).
`default_nettype none
`include "assert_macros.svh"
module binary_pepper_noise_removal (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] pixel_in
  input  wire logic                          s_tuser,   // [0] mode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [7:0]                    m_tdata,   // [7:0] pixel_out
  output logic                               m_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpnr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bpnr_pkg::DATA_W-1:0]   pwdata,
  output logic      [bpnr_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int PW = bpnr_pkg::PIX_W;
  localparam int CW = bpnr_pkg::COL_W;
  localparam int NW = bpnr_pkg::WIN;

  // configuration
  logic [bpnr_pkg::CFG_W_BITS-1:0]           frame_width;
  logic [bpnr_pkg::CFG_H_BITS-1:0]           frame_height;
  logic [bpnr_pkg::EW_W-1:0]                 eff_w;
  logic [bpnr_pkg::CFG_H_BITS-1:0]           eff_h;
  logic [bpnr_pkg::TOT_W-1:0]                tot;
  logic [bpnr_pkg::LAG_W-1:0]                lag;
  logic                                      cfg_wr;
  logic                                      cfg_idx;
  logic [bpnr_pkg::EW_W-1:0]                 new_w;
  logic [bpnr_pkg::CFG_H_BITS-1:0]           new_h;
  logic [bpnr_pkg::EW_W+bpnr_pkg::CFG_H_BITS-1:0] prod_w;
  logic [bpnr_pkg::EW_W+bpnr_pkg::CFG_H_BITS-1:0] prod_h;
  logic [bpnr_pkg::LAG_W-1:0]                lag_new;

  // front end
  bpnr_pkg::phase_t                          phase;
  bpnr_pkg::phase_t                          phase_next;
  logic [CW-1:0]                             in_col;
  logic [CW-1:0]                             in_col_next;
  logic [bpnr_pkg::ROW_W-1:0]                in_row;
  logic [bpnr_pkg::ROW_W-1:0]                in_row_next;
  logic [bpnr_pkg::LIN_W-1:0]                lin;
  logic [bpnr_pkg::LIN_W-1:0]                lin_next;
  logic [bpnr_pkg::LIN_W-1:0]                out_pos;
  logic                                      a_go;
  logic                                      a_fire;
  logic                                      a_emit;
  logic                                      a_last;
  logic                                      a_auto;
  logic                                      col_end;
  logic                                      row_end;

  // window stage
  logic                                      b_valid;
  logic [PW-1:0]                             b_px;
  logic [CW-1:0]                             b_col;
  logic                                      b_win;
  logic                                      b_clr;
  logic                                      b_emit;
  logic                                      b_last;
  logic                                      b_adv;
  bpnr_pkg::stack_t                          win [NW-1];
  logic [CW-1:0]                             win_col [3];
  logic [1:0]                                skip;
  logic [1:0]                                skip_eff;
  logic [1:0]                                skip_next;
  logic [1:0]                                fwd_sel;
  bpnr_pkg::word_t                           near;
  bpnr_pkg::word_t                           rd_word;
  logic [bpnr_pkg::WORD_W-1:0]               rd_data;
  bpnr_pkg::stack_t                          nw [NW];
  bpnr_pkg::stack_t                          nf [NW];
  logic                                      ring_white;
  logic                                      centre_black;
  logic                                      do_check;
  logic                                      do_fill;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[bpnr_pkg::ADDR_W-1];
  assign new_w   = bpnr_pkg::clamp_width(pwdata[bpnr_pkg::CFG_W_BITS-1:0]);
  assign new_h   = bpnr_pkg::clamp_height(pwdata[bpnr_pkg::CFG_H_BITS-1:0]);
  assign prod_w  = {{bpnr_pkg::CFG_H_BITS{1'b0}}, new_w} * {{bpnr_pkg::EW_W{1'b0}}, eff_h};
  assign prod_h  = {{bpnr_pkg::CFG_H_BITS{1'b0}}, eff_w} * {{bpnr_pkg::EW_W{1'b0}}, new_h};
  assign lag_new = bpnr_pkg::LAG_W'({new_w, 1'b0}) + bpnr_pkg::LAG_W'(new_w)
                 + bpnr_pkg::LAG_W'(3);

  always_comb begin
    unique case (cfg_idx)
      bpnr_pkg::REG_WIDTH:  prdata = bpnr_pkg::DATA_W'(frame_width);
      bpnr_pkg::REG_HEIGHT: prdata = bpnr_pkg::DATA_W'(frame_height);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bpnr_pkg::CFG_W_BITS'(bpnr_pkg::RESET_W);
      frame_height <= bpnr_pkg::CFG_H_BITS'(bpnr_pkg::RESET_H);
      eff_w        <= bpnr_pkg::EW_W'(bpnr_pkg::RESET_W);
      eff_h        <= bpnr_pkg::CFG_H_BITS'(bpnr_pkg::RESET_H);
      tot          <= bpnr_pkg::TOT_W'(bpnr_pkg::RESET_W * bpnr_pkg::RESET_H);
      lag          <= bpnr_pkg::LAG_W'(3 * bpnr_pkg::RESET_W + 3);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bpnr_pkg::REG_WIDTH: begin
          frame_width <= pwdata[bpnr_pkg::CFG_W_BITS-1:0];
          eff_w       <= new_w;
          tot         <= bpnr_pkg::TOT_W'(prod_w);
          lag         <= lag_new;
        end
        bpnr_pkg::REG_HEIGHT: begin
          frame_height <= pwdata[bpnr_pkg::CFG_H_BITS-1:0];
          eff_h        <= new_h;
          tot          <= bpnr_pkg::TOT_W'(prod_h);
        end
      endcase
    end
  end

  // ---------------- front end: position counters, fetch ----------------
  assign a_go    = !b_valid || b_adv;
  assign a_emit  = lin >= bpnr_pkg::LIN_W'(lag);
  assign out_pos = lin - bpnr_pkg::LIN_W'(lag);
  assign a_last  = a_emit && (out_pos == bpnr_pkg::LIN_W'(tot) - bpnr_pkg::LIN_W'(1));
  assign col_end = bpnr_pkg::EW_W'(in_col) == eff_w - bpnr_pkg::EW_W'(1);
  assign row_end = in_row == eff_h - bpnr_pkg::CFG_H_BITS'(1);

  always_comb begin
    phase_next  = phase;
    in_col_next = in_col;
    in_row_next = in_row;
    lin_next    = lin;
    a_auto      = 1'b0;
    s_tready    = 1'b0;
    a_fire      = 1'b0;
    unique case (phase)
      bpnr_pkg::PH_FILL: begin
        s_tready = a_go;
        a_fire   = a_go && s_tvalid && (s_tuser == bpnr_pkg::MODE_PIXEL);
      end
      bpnr_pkg::PH_DRAIN: begin
        // advance without a beat until the first pixel is due
        a_auto   = !a_emit;
        s_tready = a_go && a_emit;
        a_fire   = a_go && (a_auto || s_tvalid);
      end
    endcase
    if (a_fire) begin
      lin_next = lin + bpnr_pkg::LIN_W'(1);
      if (col_end) begin
        in_col_next = '0;
        in_row_next = in_row + bpnr_pkg::ROW_W'(1);
        if (phase == bpnr_pkg::PH_FILL && row_end) begin
          phase_next = bpnr_pkg::PH_DRAIN;
        end
      end else begin
        in_col_next = in_col + CW'(1);
      end
      if (a_last) begin
        phase_next  = bpnr_pkg::PH_FILL;
        in_col_next = '0;
        in_row_next = '0;
        lin_next    = '0;
      end
    end
    if (cfg_wr) begin
      phase_next  = bpnr_pkg::PH_FILL;
      in_col_next = '0;
      in_row_next = '0;
      lin_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= bpnr_pkg::PH_FILL;
      in_col <= '0;
      in_row <= '0;
      lin    <= '0;
    end else begin
      phase  <= phase_next;
      in_col <= in_col_next;
      in_row <= in_row_next;
      lin    <= lin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_go) begin
      b_valid <= a_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_fire) begin
      b_px   <= s_tdata;
      b_col  <= in_col;
      b_win  <= (phase == bpnr_pkg::PH_FILL)
             && (in_row >= bpnr_pkg::ROW_W'(2 * bpnr_pkg::RADIUS))
             && (in_col >= CW'(2 * bpnr_pkg::RADIUS));
      b_clr  <= in_col == CW'(2 * bpnr_pkg::RADIUS);
      b_emit <= a_emit;
      b_last <= a_last;
    end
  end

  // ---------------- column word store ----------------
  bpnr_ram #(
    .WIDTH (bpnr_pkg::WORD_W),
    .DEPTH (bpnr_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (b_adv),
    .waddr (win_col[2]),
    .wdata (nf[NW-2][NW-1:1]),
    .re    (a_fire),
    .raddr (in_col),
    .rdata (rd_data)
  );

  assign rd_word = bpnr_pkg::word_t'(rd_data);

  // ---------------- window stage ----------------
  assign b_adv = b_valid && (!b_emit || !m_tvalid || m_tready);

  // narrow rows: the column above is still in the window registers
  assign fwd_sel = eff_w[1:0] - 2'd1;
  assign near    = (eff_w < bpnr_pkg::EW_W'(NW)) ? win[fwd_sel][NW-1:1] : rd_word;

  always_comb begin
    nw[0] = {b_px, near};
    for (int k = 1; k < NW; k++) begin
      nw[k] = win[k-1];
    end
  end

  always_comb begin
    ring_white = 1'b1;
    for (int r = 0; r < NW; r++) begin
      if (nw[0][r] == '0 || nw[NW-1][r] == '0) begin
        ring_white = 1'b0;
      end
    end
    for (int k = 1; k < NW - 1; k++) begin
      if (nw[k][0] == '0 || nw[k][NW-1] == '0) begin
        ring_white = 1'b0;
      end
    end
  end

  assign centre_black = nw[bpnr_pkg::RADIUS][bpnr_pkg::RADIUS] == '0;
  assign skip_eff     = b_clr ? 2'd0 : skip;
  assign do_check     = b_win && (skip_eff == 2'd0) && centre_black;
  assign do_fill      = do_check && ring_white;

  always_comb begin
    skip_next = skip;
    if (b_win) begin
      if (skip_eff != 2'd0) begin
        skip_next = skip_eff - 2'd1;
      end else if (centre_black) begin
        skip_next = 2'(bpnr_pkg::SKIP_LEN);
      end else begin
        skip_next = 2'd0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      nf[k] = nw[k];
    end
    if (do_fill) begin
      for (int k = 1; k < NW - 1; k++) begin
        for (int r = 1; r < NW - 1; r++) begin
          nf[k][r] = bpnr_pkg::FILL_VALUE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= 2'd0;
    end else if (b_adv) begin
      skip <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      for (int k = 0; k < NW - 1; k++) begin
        win[k] <= nf[k];
      end
      win_col[0] <= b_col;
      win_col[1] <= win_col[0];
      win_col[2] <= win_col[1];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_adv && b_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_emit) begin
      m_tdata <= nf[NW-2][1];
      m_tlast <= b_last;
    end
  end

  `BPNR_ASSERT(a_drain_beat_emits, (phase == bpnr_pkg::PH_DRAIN && s_tvalid && s_tready) |=> (b_valid && b_emit), "flush beat gave no result")
  `BPNR_ASSERT(a_last_restarts, (a_fire && a_last && !cfg_wr) |=> (phase == bpnr_pkg::PH_FILL && lin == '0), "frame did not restart after last pixel")
  `BPNR_NEVER(a_window_needs_width, b_valid && b_win && (eff_w < bpnr_pkg::EW_W'(NW)), "window check on a row narrower than the window")
  `BPNR_ASSERT(a_skip_after_black, (b_adv && do_check) |=> (skip == 2'(bpnr_pkg::SKIP_LEN)), "skip not armed after black centre")

endmodule
`default_nettype wire
